FILE: src/button_press_classifier_assert.svh
// Assertion macros used by the checker file of the button press classifier.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Property checked only while the block is out of reset.
`define BPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned StampW  = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned ActW    = 3;

  localparam logic [CfgW-1:0] LongPressRst   = 16'd1000;
  localparam logic [CfgW-1:0] RestartWinRst  = 16'd2000;

  typedef enum logic [ActW-1:0] {
    ACT_NONE        = 3'd0,
    ACT_NEXT        = 3'd1,
    ACT_NEXT_FOLDER = 3'd2,
    ACT_PREV        = 3'd3,
    ACT_RESTART     = 3'd4,
    ACT_PREV_FOLDER = 3'd5,
    ACT_CHANGE_MODE = 3'd6
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS = 1'b0,
    CFG_RESTART_WIN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [StampW-1:0] now_ms;
    logic              fwd_level;
    logic              back_level;
    logic              menu_level;
    logic              folder_mode;
  } item_t;

  typedef struct packed {
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] restart_window_ms;
  } cfg_t;

  typedef struct packed {
    logic              fwd_was;
    logic              back_was;
    logic              menu_was;
    logic [StampW-1:0] fwd_stamp;
    logic [StampW-1:0] back_stamp;
    logic [StampW-1:0] last_back_stamp;
  } btn_state_t;

endpackage

FILE: src/button_press_classifier.sv
// Pipeline: the input register takes the item at its transfer edge, and the result register
// takes the action from it at an edge where it is empty or its result is being taken.
// Throughput: one item per cycle; a waiting result still lets one more item into the input
// register, and the input stalls only when both stages are full and the result is stalled.
// Reset (rst_ni low, asynchronous): both pipeline stages empty, button levels released,
// all stamps zero, long press threshold 1000 ms, restart window 2000 ms.
module button_press_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bpc_pkg::CfgW-1:0]    cfg_wdata_i,
  // Input item channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bpc_pkg::StampW-1:0]  now_ms_i,
  input  logic                        fwd_level_i,
  input  logic                        back_level_i,
  input  logic                        menu_level_i,
  input  logic                        folder_mode_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bpc_pkg::ActW-1:0]    action_o
);
  import bpc_pkg::*;

  // Configuration registers. Writes always taken; user must write while idle, not enforced.
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms     <= LongPressRst;
      cfg_q.restart_window_ms <= RestartWinRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LONG_PRESS:  cfg_q.long_press_ms     <= cfg_wdata_i;
        CFG_RESTART_WIN: cfg_q.restart_window_ms <= cfg_wdata_i;
        default:         cfg_q                   <= cfg_q;
      endcase
    end
  end

  // Result register.
  logic    out_valid_q;
  action_e action_q;

  // The input register holds one sampled item. It moves on into the result register whenever
  // the result register is empty or its result is being taken in this cycle, so the input side
  // only stalls when both stages are full and the consumer is stalling.
  logic       s1_valid_q;
  item_t      s1_item_q;
  logic       advance;
  logic       in_xfer;
  logic       fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.now_ms      <= now_ms_i;
      s1_item_q.fwd_level   <= fwd_level_i;
      s1_item_q.back_level  <= back_level_i;
      s1_item_q.menu_level  <= menu_level_i;
      s1_item_q.folder_mode <= folder_mode_i;
    end
  end

  // Classification of the registered item against the button history. The history is
  // committed in the same edge as the result, so the next item sees it immediately.
  btn_state_t state_q, state_d;
  action_e    action_d;

  bpc_decide u_decide (
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .action_o (action_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      action_q <= action_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;

endmodule

FILE: src/bpc_decide.sv
module bpc_decide (
  input  bpc_pkg::item_t      item_i,
  input  bpc_pkg::cfg_t       cfg_i,
  input  bpc_pkg::btn_state_t state_i,
  output bpc_pkg::btn_state_t state_o,
  output bpc_pkg::action_e    action_o
);
  import bpc_pkg::*;

  logic [StampW-1:0] fwd_dur, back_dur, since_back;
  logic              fwd_rise, fwd_fall, fwd_long, fwd_stop;
  logic              back_rise, back_fall, back_long, back_stop;
  logic              menu_fall;

  assign fwd_rise   = item_i.fwd_level & ~state_i.fwd_was;
  assign fwd_fall   = ~item_i.fwd_level & state_i.fwd_was;
  assign fwd_dur    = item_i.now_ms - state_i.fwd_stamp;
  assign fwd_long   = fwd_dur >= {{(StampW-CfgW){1'b0}}, cfg_i.long_press_ms};
  // A long forward press outside folder mode produces nothing and lets back be examined.
  assign fwd_stop   = fwd_fall & (~fwd_long | item_i.folder_mode);

  assign back_rise  = item_i.back_level & ~state_i.back_was;
  assign back_fall  = ~item_i.back_level & state_i.back_was;
  assign back_dur   = item_i.now_ms - state_i.back_stamp;
  assign back_long  = back_dur >= {{(StampW-CfgW){1'b0}}, cfg_i.long_press_ms};
  assign back_stop  = back_fall & (~back_long | item_i.folder_mode);
  assign since_back = item_i.now_ms - state_i.last_back_stamp;

  assign menu_fall  = ~item_i.menu_level & state_i.menu_was;

  always_comb begin
    state_o  = state_i;
    action_o = ACT_NONE;

    state_o.fwd_was = item_i.fwd_level;
    if (fwd_rise) begin
      state_o.fwd_stamp = item_i.now_ms;
    end

    if (fwd_stop) begin
      action_o = fwd_long ? ACT_NEXT_FOLDER : ACT_NEXT;
    end else begin
      state_o.back_was = item_i.back_level;
      if (back_rise) begin
        state_o.back_stamp = item_i.now_ms;
      end
      if (back_fall && !back_long) begin
        state_o.last_back_stamp = item_i.now_ms;
      end

      if (back_stop) begin
        if (back_long) begin
          action_o = ACT_PREV_FOLDER;
        end else if (since_back < {{(StampW-CfgW){1'b0}}, cfg_i.restart_window_ms}) begin
          action_o = ACT_PREV;
        end else begin
          action_o = ACT_RESTART;
        end
      end else begin
        state_o.menu_was = item_i.menu_level;
        if (menu_fall) begin
          action_o = ACT_CHANGE_MODE;
        end
      end
    end
  end

endmodule

FILE: src/bpc_checker.sv
`include "button_press_classifier_assert.svh"

module bpc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bpc_pkg::ActW-1:0]    action_o
);
  import bpc_pkg::*;

  // A stalled result stays in place.
  `BPC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o), "stalled result changed")

  // Only defined action codes leave the block.
  `BPC_ASSERT(a_action_code, out_valid_o |-> action_o <= ACT_CHANGE_MODE, "undefined action code")

  // With the result register empty, the input side never stalls.
  `BPC_ASSERT(a_no_stall_empty, !out_valid_o |-> !in_stall_o, "input stalled with empty output")

  // Reset empties the result register.
  `BPC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);
